>>> rtl/mi3_pkg.sv
// ----------------------------------------------------------------------------
// mi3_pkg
// Shared types and constants for the 3x3 adjugate matrix inverse.
// ----------------------------------------------------------------------------
package mi3_pkg;

    // Fixed field width of every matrix element word.
    localparam int FIELD_W = 32;

    // One input word: a 3x3 matrix in row-major order.
    typedef struct packed {
        logic signed [FIELD_W-1:0] in_r1c1;
        logic signed [FIELD_W-1:0] in_r1c2;
        logic signed [FIELD_W-1:0] in_r1c3;
        logic signed [FIELD_W-1:0] in_r2c1;
        logic signed [FIELD_W-1:0] in_r2c2;
        logic signed [FIELD_W-1:0] in_r2c3;
        logic signed [FIELD_W-1:0] in_r3c1;
        logic signed [FIELD_W-1:0] in_r3c2;
        logic signed [FIELD_W-1:0] in_r3c3;
    } mat_in_t;

    // One result word: the saturated inverse and the singular flag.
    typedef struct packed {
        logic signed [FIELD_W-1:0] inv_r1c1;
        logic signed [FIELD_W-1:0] inv_r1c2;
        logic signed [FIELD_W-1:0] inv_r1c3;
        logic signed [FIELD_W-1:0] inv_r2c1;
        logic signed [FIELD_W-1:0] inv_r2c2;
        logic signed [FIELD_W-1:0] inv_r2c3;
        logic signed [FIELD_W-1:0] inv_r3c1;
        logic signed [FIELD_W-1:0] inv_r3c2;
        logic signed [FIELD_W-1:0] inv_r3c3;
        logic                      singular;
    } mat_out_t;

endpackage

>>> rtl/matrix_inverse_3x3.sv
// ----------------------------------------------------------------------------
// matrix_inverse_3x3
// Pipelined 3x3 inverse by adjugate and determinant, Q-format, saturated.
// ----------------------------------------------------------------------------
// Usage: drive a matrix word on mat and raise start; it is taken at any
// clock edge where start is high, since busy is always low. Every cycle
// may carry a new word. Each result word appears on result for one
// cycle with done high, and the receiver must take it then.
// Pipeline: 4 cofactor stages, one setup stage, one restoring divider
// stage per numerator bit (2*ELEM_WIDTH+2*FRAC_BITS of them), and one
// output stage. Throughput is one matrix per cycle, set by the fully
// unrolled divider pipeline.
// Reset clears all valid bits; words in flight are dropped.
// A zero determinant gives an all-zero inverse with singular set.
// ----------------------------------------------------------------------------
module matrix_inverse_3x3 #(
    parameter int ELEM_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  mi3_pkg::mat_in_t   mat,
    output logic               busy,
    output logic               done,
    output mi3_pkg::mat_out_t  result
);

    localparam int EW    = ELEM_WIDTH;
    localparam int AW    = 2 * EW + 1;
    localparam int DW    = 3 * EW + 2;
    localparam int MW    = 2 * EW;                 // adj magnitude width
    localparam int NUM_W = MW + 2 * FRAC_BITS;
    localparam int DEN_W = DW;
    localparam int STEPS = NUM_W;
    localparam int QW    = EW + 2;
    localparam int TAG_W = 10;
    localparam int FW    = mi3_pkg::FIELD_W;

    logic                 cf_valid;
    logic signed [AW-1:0] cf_adj [9];
    logic signed [DW-1:0] cf_det;

    mi3_cofactor #(.ELEM_WIDTH(EW)) u_cof (
        .clk(clk), .rst_n(rst_n), .valid_in(start && !busy), .mat(mat),
        .valid_out(cf_valid), .adj(cf_adj), .det(cf_det)
    );

    // Setup: magnitudes, scaled numerators, sign tags and the singular tag.
    logic             s_valid_reg;
    logic [NUM_W-1:0] s_num_reg [9];
    logic [DEN_W-1:0] s_den_reg;
    logic [TAG_W-1:0] s_tag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s_valid_reg <= 1'b0;
        else
            s_valid_reg <= cf_valid;
    end

    always_ff @(posedge clk)
    begin
        logic [AW-1:0] m;
        logic [DW-1:0] dm;
        dm = cf_det[DW-1] ? DW'(-cf_det) : DW'(cf_det);
        s_den_reg <= dm;
        s_tag_reg[9] <= (cf_det == '0);
        for (int k = 0; k < 9; k++)
        begin
            m = cf_adj[k][AW-1] ? AW'(-cf_adj[k]) : AW'(cf_adj[k]);
            s_num_reg[k] <= {m[MW-1:0], {(2*FRAC_BITS){1'b0}}};
            s_tag_reg[k] <= cf_adj[k][AW-1] ^ cf_det[DW-1];
        end
    end

    // Divider pipeline: one quotient bit per stage; the top bits are kept
    // only as an overflow indicator in the quotient's upper bit.
    logic             d_valid [STEPS+1];
    logic [NUM_W-1:0] d_num   [STEPS+1][9];
    logic [DEN_W:0]   d_rem   [STEPS+1][9];
    logic [QW-1:0]    d_quo   [STEPS+1][9];
    logic [DEN_W-1:0] d_den   [STEPS+1];
    logic [TAG_W-1:0] d_tag   [STEPS+1];
    logic             d_ovf   [9];

    assign d_valid[0] = s_valid_reg;
    assign d_num[0]   = s_num_reg;
    assign d_den[0]   = s_den_reg;
    assign d_tag[0]   = s_tag_reg;
    assign d_rem[0]   = '{default: '0};
    assign d_quo[0]   = '{default: '0};

    genvar g;
    generate
        for (g = 0; g < STEPS; g++)
        begin : g_div
            mi3_div_stage #(
                .NUM_W(NUM_W), .DEN_W(DEN_W), .QW(QW), .TAG_W(TAG_W)
            ) u_stage (
                .clk(clk), .rst_n(rst_n),
                .valid_in(d_valid[g]), .num_in(d_num[g]), .rem_in(d_rem[g]),
                .quo_in(d_quo[g]), .den_in(d_den[g]), .tag_in(d_tag[g]),
                .valid_out(d_valid[g+1]), .num_out(d_num[g+1]),
                .rem_out(d_rem[g+1]), .quo_out(d_quo[g+1]),
                .den_out(d_den[g+1]), .tag_out(d_tag[g+1])
            );
        end
    endgenerate

    // Sticky overflow: a quotient bit shifted past QW bits sets it.
    logic [STEPS-1:0] ovf_reg [9];
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 9; k++)
            for (int s = 0; s < STEPS; s++)
                if (s == 0)
                    ovf_reg[k][s] <= 1'b0;
                else
                    ovf_reg[k][s] <= ovf_reg[k][s-1] | d_quo[s][k][QW-1];
    end
    always_comb
    begin
        for (int k = 0; k < 9; k++)
            d_ovf[k] = d_quo[STEPS][k][QW-1] | ovf_reg[k][STEPS-1];
    end

    // Output stage: sign, saturation, singular forcing.
    logic              o_valid_reg;
    mi3_pkg::mat_out_t o_res_reg;
    logic [FW-1:0]     v [9];

    always_comb
    begin
        logic [QW-1:0] q;
        logic          big;
        logic [QW-1:0] lim;
        lim = QW'(1) << (EW - 1);
        for (int k = 0; k < 9; k++)
        begin
            q   = d_quo[STEPS][k];
            big = d_ovf[k];
            if (d_tag[STEPS][k])
            begin
                if (big || q > lim)
                    q = lim;
                q = -q;
            end
            else if (big || q > lim - QW'(1))
                q = lim - QW'(1);
            v[k] = d_tag[STEPS][9] ? '0 : FW'($signed(q[EW-1:0]));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            o_valid_reg <= 1'b0;
        else
            o_valid_reg <= d_valid[STEPS];
    end

    always_ff @(posedge clk)
    begin
        o_res_reg.inv_r1c1 <= v[0];
        o_res_reg.inv_r1c2 <= v[1];
        o_res_reg.inv_r1c3 <= v[2];
        o_res_reg.inv_r2c1 <= v[3];
        o_res_reg.inv_r2c2 <= v[4];
        o_res_reg.inv_r2c3 <= v[5];
        o_res_reg.inv_r3c1 <= v[6];
        o_res_reg.inv_r3c2 <= v[7];
        o_res_reg.inv_r3c3 <= v[8];
        o_res_reg.singular <= d_tag[STEPS][9];
    end

    assign busy   = 1'b0;
    assign done   = o_valid_reg;
    assign result = o_res_reg;

    // A singular result carries zeros in inv_r1c1 and inv_r3c3.
    a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.singular |-> result.inv_r1c1 == '0 && result.inv_r3c3 == '0)
        else $error("singular result not zero");

    // Every word in the setup stage emerges on done after the divider and output stages.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s_valid_reg |-> ##(STEPS+1) done)
        else $error("word lost in divider pipeline");

    // Nothing leaves the divider pipeline without a word entering it earlier.
    a_no_ghost: assert property (@(posedge clk) disable iff (!rst_n)
        d_valid[STEPS] |-> $past(s_valid_reg, STEPS))
        else $error("spurious word from divider");

endmodule

>>> rtl/mi3_div_stage.sv
// ----------------------------------------------------------------------------
// mi3_div_stage
// One radix-2 restoring step for nine parallel quotient lanes.
// ----------------------------------------------------------------------------
module mi3_div_stage #(
    parameter int NUM_W = 96,
    parameter int DEN_W = 96,
    parameter int QW    = 34,
    parameter int TAG_W = 10
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 valid_in,
    input  logic [NUM_W-1:0]     num_in [9],
    input  logic [DEN_W:0]       rem_in [9],
    input  logic [QW-1:0]        quo_in [9],
    input  logic [DEN_W-1:0]     den_in,
    input  logic [TAG_W-1:0]     tag_in,
    output logic                 valid_out,
    output logic [NUM_W-1:0]     num_out [9],
    output logic [DEN_W:0]       rem_out [9],
    output logic [QW-1:0]        quo_out [9],
    output logic [DEN_W-1:0]     den_out,
    output logic [TAG_W-1:0]     tag_out
);

    logic [NUM_W-1:0] num_next [9];
    logic [DEN_W:0]   rem_next [9];
    logic [QW-1:0]    quo_next [9];
    logic             valid_reg;
    logic [NUM_W-1:0] num_reg [9];
    logic [DEN_W:0]   rem_reg [9];
    logic [QW-1:0]    quo_reg [9];
    logic [DEN_W-1:0] den_reg;
    logic [TAG_W-1:0] tag_reg;

    // Shift in one numerator bit and try to subtract the divisor.
    always_comb
    begin
        for (int k = 0; k < 9; k++)
        begin
            logic [DEN_W+1:0] trial;
            trial = {rem_in[k], num_in[k][NUM_W-1]} - {2'b00, den_in};
            num_next[k] = {num_in[k][NUM_W-2:0], 1'b0};
            if (!trial[DEN_W+1])
            begin
                rem_next[k] = trial[DEN_W:0];
                quo_next[k] = {quo_in[k][QW-2:0], 1'b1};
            end
            else
            begin
                rem_next[k] = {rem_in[k][DEN_W-1:0], num_in[k][NUM_W-1]};
                quo_next[k] = {quo_in[k][QW-2:0], 1'b0};
            end
        end
    end

    // Valid bit resets; payload follows it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_in;
        tag_reg <= tag_in;
    end

    assign valid_out = valid_reg;
    assign num_out   = num_reg;
    assign rem_out   = rem_reg;
    assign quo_out   = quo_reg;
    assign den_out   = den_reg;
    assign tag_out   = tag_reg;

endmodule

>>> rtl/mi3_cofactor.sv
// ----------------------------------------------------------------------------
// mi3_cofactor
// Registered cofactor products, adjugate, and determinant in four stages.
// ----------------------------------------------------------------------------
module mi3_cofactor #(
    parameter int ELEM_WIDTH = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         valid_in,
    input  mi3_pkg::mat_in_t             mat,
    output logic                         valid_out,
    output logic signed [2*ELEM_WIDTH:0] adj [9],
    output logic signed [3*ELEM_WIDTH+1:0] det
);

    localparam int EW = ELEM_WIDTH;
    localparam int PW = 2 * EW;
    localparam int AW = 2 * EW + 1;
    localparam int DW = 3 * EW + 2;

    logic signed [EW-1:0] a [9];
    logic signed [EW-1:0] a_reg [3];
    logic signed [PW-1:0] p_reg [18];
    logic signed [AW-1:0] adj_reg [9];
    logic signed [EW-1:0] e_reg [3];
    logic signed [AW-1:0] t_lo_reg [3];
    logic signed [AW-1:0] t_hi_reg [3];
    logic signed [AW-1:0] adj2_reg [9];
    logic signed [DW-1:0] det_reg;
    logic [3:0]           v_reg;

    // Only the low element bits of each field are used.
    assign a[0] = mat.in_r1c1[EW-1:0];
    assign a[1] = mat.in_r1c2[EW-1:0];
    assign a[2] = mat.in_r1c3[EW-1:0];
    assign a[3] = mat.in_r2c1[EW-1:0];
    assign a[4] = mat.in_r2c2[EW-1:0];
    assign a[5] = mat.in_r2c3[EW-1:0];
    assign a[6] = mat.in_r3c1[EW-1:0];
    assign a[7] = mat.in_r3c2[EW-1:0];
    assign a[8] = mat.in_r3c3[EW-1:0];

    // Valid bits travel along the four stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= {v_reg[2:0], valid_in};
    end

    // Stage 1: eighteen element products; stage 2: adjugate differences.
    always_ff @(posedge clk)
    begin
        a_reg[0] <= a[0];
        a_reg[1] <= a[1];
        a_reg[2] <= a[2];
        p_reg[0]  <= a[4] * a[8];  p_reg[1]  <= a[5] * a[7];
        p_reg[2]  <= a[2] * a[7];  p_reg[3]  <= a[1] * a[8];
        p_reg[4]  <= a[1] * a[5];  p_reg[5]  <= a[2] * a[4];
        p_reg[6]  <= a[5] * a[6];  p_reg[7]  <= a[3] * a[8];
        p_reg[8]  <= a[0] * a[8];  p_reg[9]  <= a[2] * a[6];
        p_reg[10] <= a[2] * a[3];  p_reg[11] <= a[0] * a[5];
        p_reg[12] <= a[3] * a[7];  p_reg[13] <= a[4] * a[6];
        p_reg[14] <= a[1] * a[6];  p_reg[15] <= a[0] * a[7];
        p_reg[16] <= a[0] * a[4];  p_reg[17] <= a[1] * a[3];
        for (int k = 0; k < 9; k++)
            adj_reg[k] <= AW'(p_reg[2*k]) - AW'(p_reg[2*k+1]);
        e_reg[0] <= a_reg[0];
        e_reg[1] <= a_reg[1];
        e_reg[2] <= a_reg[2];
    end

    // Stage 3: first-row expansion terms, each cofactor split into a low
    // unsigned half and a high signed half; stage 4: the weighted sum.
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            t_lo_reg[k] <= e_reg[k] * $signed({1'b0, adj_reg[3*k][EW-1:0]});
            t_hi_reg[k] <= e_reg[k] * $signed(adj_reg[3*k][AW-1:EW]);
        end
        adj2_reg <= adj_reg;
        det_reg  <= ((DW'(t_hi_reg[0]) + DW'(t_hi_reg[1]) + DW'(t_hi_reg[2])) << EW)
                    + DW'(t_lo_reg[0]) + DW'(t_lo_reg[1]) + DW'(t_lo_reg[2]);
        adj      <= adj2_reg;
    end

    assign valid_out = v_reg[3];
    assign det       = det_reg;

endmodule
